### hw/rtl/tds_pkg.sv
package tds_pkg;

  // Timer counter width; reload and prescale factor range follow from it.
  localparam int unsigned COUNTER_BITS = 16;

  localparam int unsigned TARGET_W = 20;
  localparam int unsigned CLK_W    = 29;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned ERR_W    = 32;

  localparam int unsigned CNT_W      = COUNTER_BITS + 1;       // period / factor
  localparam int unsigned PROD_W     = 2 * CNT_W;              // factor * period
  localparam int unsigned DIV_CNT_W  = $clog2(CLK_W + 1);
  localparam int unsigned MAX_FACTOR = 1 << COUNTER_BITS;

  localparam int unsigned MAX_TARGET_RATE = 500000;
  localparam int unsigned CLOCK_RESET     = 300000000;
  localparam int unsigned FIRST_RELOAD    = 9;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_INVALID = 2'd1,
    ST_NONE    = 2'd2
  } tds_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_N,
    S_CHECK,
    S_DIV_Q,
    S_MUL,
    S_ACT_GO,
    S_DIV_ACT,
    S_EVAL,
    S_NEXT,
    S_DONE
  } tds_state_e;

  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [PROD_W-1:0] divisor;
  } tds_div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } tds_div_rsp_t;

  typedef struct packed {
    logic [FIELD_W-1:0] reload_value;
    logic [FIELD_W-1:0] prescale_value;
    logic [CLK_W-1:0]   achieved_rate;
    logic [ERR_W-1:0]   rate_error;
    tds_status_e        status;
  } tds_res_t;

endpackage

### hw/rtl/tds_serial_div.sv
// Restoring divider, one quotient bit per cycle through a shift register.
module tds_serial_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tds_pkg::tds_div_req_t req_i,
  output tds_pkg::tds_div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [tds_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [tds_pkg::CLK_W-1:0]     quot_q, quot_d;
  logic [tds_pkg::PROD_W-1:0]    rem_q, rem_d;
  logic [tds_pkg::PROD_W-1:0]    dvs_q, dvs_d;

  logic [tds_pkg::PROD_W:0] rem_sh;
  logic                     ge;

  assign rem_sh = {rem_q, quot_q[tds_pkg::CLK_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = tds_pkg::DIV_CNT_W'(tds_pkg::CLK_W);
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? tds_pkg::PROD_W'(rem_sh - {1'b0, dvs_q}) : tds_pkg::PROD_W'(rem_sh);
      quot_d = {quot_q[tds_pkg::CLK_W-2:0], ge};
      cnt_d  = cnt_q - tds_pkg::DIV_CNT_W'(1);
      if (cnt_q == tds_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

### hw/rtl/tds_search.sv
// Reload / prescale search sequencer; all divisions go to the shared serial divider.
module tds_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tds_pkg::TARGET_W-1:0] target_rate_i,
  input  logic [tds_pkg::CLK_W-1:0]    timer_clock_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output tds_pkg::tds_res_t            res_o,
  output tds_pkg::tds_div_req_t        div_req_o,
  input  tds_pkg::tds_div_rsp_t        div_rsp_i
);

  tds_pkg::tds_state_e state_q, state_d;

  logic [tds_pkg::TARGET_W-1:0]     rate_q, rate_d;
  logic [tds_pkg::CLK_W-1:0]        n_q, n_d;
  logic [tds_pkg::CNT_W-1:0]        period_q, period_d;
  logic [tds_pkg::CNT_W-1:0]        q_q, q_d;
  logic [tds_pkg::CNT_W-1:0]        p_q, p_d;
  logic [tds_pkg::PROD_W-1:0]       prod_q, prod_d;
  logic [tds_pkg::CLK_W-1:0]        act_q, act_d;
  logic [tds_pkg::COUNTER_BITS-1:0] best_arr_q, best_arr_d;
  logic [tds_pkg::COUNTER_BITS-1:0] best_pre_q, best_pre_d;
  logic [tds_pkg::CLK_W-1:0]        best_rate_q, best_rate_d;
  logic [tds_pkg::ERR_W-1:0]        best_err_q, best_err_d;
  logic                             found_q, found_d;
  logic                             invalid_q, invalid_d;

  logic [tds_pkg::CLK_W-1:0] rate_ext;
  logic [tds_pkg::CLK_W-1:0] err;
  logic                      last_p;

  assign rate_ext = tds_pkg::CLK_W'(rate_q);
  assign err      = (act_q > rate_ext) ? act_q - rate_ext : rate_ext - act_q;
  // last factor: q+1, or q when q+1 would exceed the counter range
  assign last_p   = ({1'b0, p_q} == ({1'b0, q_q} + (tds_pkg::CNT_W + 1)'(1))) ||
                    ((p_q == q_q) && (q_q == tds_pkg::CNT_W'(tds_pkg::MAX_FACTOR)));

  always_comb begin
    state_d     = state_q;
    rate_d      = rate_q;
    n_d         = n_q;
    period_d    = period_q;
    q_d         = q_q;
    p_d         = p_q;
    prod_d      = prod_q;
    act_d       = act_q;
    best_arr_d  = best_arr_q;
    best_pre_d  = best_pre_q;
    best_rate_d = best_rate_q;
    best_err_d  = best_err_q;
    found_d     = found_q;
    invalid_d   = invalid_q;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = timer_clock_i;
    div_req_o.divisor  = tds_pkg::PROD_W'(prod_q);

    unique case (state_q)
      tds_pkg::S_IDLE: begin
        if (start_i) begin
          rate_d      = target_rate_i;
          found_d     = 1'b0;
          best_err_d  = '1;
          best_arr_d  = '0;
          best_pre_d  = '0;
          best_rate_d = '0;
          if (target_rate_i == '0 ||
              target_rate_i > tds_pkg::TARGET_W'(tds_pkg::MAX_TARGET_RATE)) begin
            invalid_d = 1'b1;
            state_d   = tds_pkg::S_DONE;
          end else begin
            invalid_d          = 1'b0;
            div_req_o.start    = 1'b1;
            div_req_o.divisor  = tds_pkg::PROD_W'(target_rate_i);
            state_d            = tds_pkg::S_DIV_N;
          end
        end
      end
      tds_pkg::S_DIV_N: begin
        if (div_rsp_i.done) begin
          n_d      = div_rsp_i.quotient;
          period_d = tds_pkg::CNT_W'(tds_pkg::FIRST_RELOAD + 1);
          state_d  = tds_pkg::S_CHECK;
        end
      end
      tds_pkg::S_CHECK: begin
        if (n_q < tds_pkg::CLK_W'(period_q)) begin
          state_d = tds_pkg::S_DONE;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = n_q;
          div_req_o.divisor  = tds_pkg::PROD_W'(period_q);
          state_d            = tds_pkg::S_DIV_Q;
        end
      end
      tds_pkg::S_DIV_Q: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.quotient > tds_pkg::CLK_W'(tds_pkg::MAX_FACTOR)) begin
            state_d = tds_pkg::S_NEXT;
          end else begin
            q_d     = tds_pkg::CNT_W'(div_rsp_i.quotient);
            p_d     = (div_rsp_i.quotient > tds_pkg::CLK_W'(1)) ?
                      tds_pkg::CNT_W'(div_rsp_i.quotient - tds_pkg::CLK_W'(1)) :
                      tds_pkg::CNT_W'(1);
            state_d = tds_pkg::S_MUL;
          end
        end
      end
      tds_pkg::S_MUL: begin
        prod_d  = tds_pkg::PROD_W'(p_q) * tds_pkg::PROD_W'(period_q);
        state_d = tds_pkg::S_ACT_GO;
      end
      tds_pkg::S_ACT_GO: begin
        div_req_o.start = 1'b1;
        state_d         = tds_pkg::S_DIV_ACT;
      end
      tds_pkg::S_DIV_ACT: begin
        if (div_rsp_i.done) begin
          act_d   = div_rsp_i.quotient;
          state_d = tds_pkg::S_EVAL;
        end
      end
      tds_pkg::S_EVAL: begin
        if (tds_pkg::ERR_W'(err) < best_err_q) begin
          best_err_d  = tds_pkg::ERR_W'(err);
          best_arr_d  = tds_pkg::COUNTER_BITS'(period_q - tds_pkg::CNT_W'(1));
          best_pre_d  = tds_pkg::COUNTER_BITS'(p_q - tds_pkg::CNT_W'(1));
          best_rate_d = act_q;
          found_d     = 1'b1;
        end
        priority if (err == '0) begin
          state_d = tds_pkg::S_DONE;    // exact match ends the search
        end else if (last_p) begin
          state_d = tds_pkg::S_NEXT;
        end else begin
          p_d     = p_q + tds_pkg::CNT_W'(1);
          state_d = tds_pkg::S_MUL;
        end
      end
      tds_pkg::S_NEXT: begin
        if (period_q == tds_pkg::CNT_W'(tds_pkg::MAX_FACTOR)) begin
          state_d = tds_pkg::S_DONE;
        end else begin
          period_d = period_q + tds_pkg::CNT_W'(1);
          state_d  = tds_pkg::S_CHECK;
        end
      end
      tds_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = tds_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tds_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tds_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q      <= rate_d;
    n_q         <= n_d;
    period_q    <= period_d;
    q_q         <= q_d;
    p_q         <= p_d;
    prod_q      <= prod_d;
    act_q       <= act_d;
    best_arr_q  <= best_arr_d;
    best_pre_q  <= best_pre_d;
    best_rate_q <= best_rate_d;
    best_err_q  <= best_err_d;
    found_q     <= found_d;
    invalid_q   <= invalid_d;
  end

  assign idle_o      = (state_q == tds_pkg::S_IDLE);
  assign res_valid_o = (state_q == tds_pkg::S_DONE);

  always_comb begin
    priority if (invalid_q) begin
      res_o.reload_value   = '0;
      res_o.prescale_value = '0;
      res_o.achieved_rate  = '0;
      res_o.rate_error     = '1;
      res_o.status         = tds_pkg::ST_INVALID;
    end else if (!found_q) begin
      res_o.reload_value   = '0;
      res_o.prescale_value = '0;
      res_o.achieved_rate  = timer_clock_i;
      res_o.rate_error     = '1;
      res_o.status         = tds_pkg::ST_NONE;
    end else begin
      res_o.reload_value   = tds_pkg::FIELD_W'(best_arr_q);
      res_o.prescale_value = tds_pkg::FIELD_W'(best_pre_q);
      res_o.achieved_rate  = best_rate_q;
      res_o.rate_error     = best_err_q;
      res_o.status         = tds_pkg::ST_FOUND;
    end
  end

endmodule

### hw/rtl/timer_divider_search.sv
// Channel    | Dir | Payload
// s_axis     | in  | tdata[19:0] target_rate
// m_axis     | out | tdata: reload, prescale, achieved rate, error; tuser: status
// cfg        | in  | cfg_wdata_i[28:0] timer clock in Hz, written when cfg_we_i
//
// One request at a time. Every division runs on the one bit-serial divider;
// each reload step needs one division for its factor and up to three for
// candidate rates. Invalid rates go straight to the result without a division.
// Reset clears the sequencer and output valid; the clock register resets to
// 300 MHz; a stalled result sits in the output register while the next request is taken.
module timer_divider_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] target_rate, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [15:0] reload, [31:16] prescale,
                                      // [60:32] achieved rate, [92:61] error
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_we_i,
  input  logic [28:0] cfg_wdata_i
);

  logic [tds_pkg::CLK_W-1:0] clk_hz_q;

  logic                  srch_idle;
  logic                  res_valid;
  logic                  res_take;
  tds_pkg::tds_res_t     res;
  tds_pkg::tds_div_req_t div_req;
  tds_pkg::tds_div_rsp_t div_rsp;

  logic                  out_valid_q;
  tds_pkg::tds_res_t     out_q;

  // timer clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= tds_pkg::CLK_W'(tds_pkg::CLOCK_RESET);
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_wdata_i;
    end
  end

  tds_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tds_search u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (s_axis_tvalid && s_axis_tready),
    .target_rate_i (s_axis_tdata[tds_pkg::TARGET_W-1:0]),
    .timer_clock_i (clk_hz_q),
    .idle_o        (srch_idle),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_take),
    .res_o         (res),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp)
  );

  assign s_axis_tready = srch_idle;

  // output register; search result moves in when it is empty or draining
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.rate_error, out_q.achieved_rate,
                          out_q.prescale_value, out_q.reload_value};
  assign m_axis_tuser  = out_q.status;

  // a new request is never taken while a search runs
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while search busy");

  a_invalid_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tds_pkg::ST_INVALID) |->
      (m_axis_tdata[92:61] == 32'hFFFF_FFFF) && (m_axis_tdata[60:0] == '0))
    else $error("invalid-rate result carries nonzero fields");

  a_none_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tds_pkg::ST_NONE) |->
      (m_axis_tdata[92:61] == 32'hFFFF_FFFF) && (m_axis_tdata[31:0] == '0))
    else $error("no-candidate result carries a reload or prescale");

endmodule
